/* design/lca_pkg.sv */
// ----------------------------------------------------------------------------
// Lease consensus acceptor package
// Shared request/reply codes, register indexes and the structs passed between
// the acceptor core and its decision logic.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Request type codes (code 3 is unused and acts like a tick)
  typedef enum logic [1:0] {
    REQ_PREPARE = 2'd0,
    REQ_PROPOSE = 2'd1,
    REQ_TICK    = 2'd2
  } req_type_t;

  // Reply kind codes
  typedef enum logic [2:0] {
    KIND_PREP_REJECT = 3'd0,
    KIND_PREP_OPEN   = 3'd1,
    KIND_PREP_PREV   = 3'd2,
    KIND_PROP_REJECT = 3'd3,
    KIND_PROP_ACCEPT = 3'd4,
    KIND_SKEW_FAULT  = 3'd5
  } reply_kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_NODE      = 2'd0;
  localparam logic [1:0] CFG_LEASE_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_SKEW_LIMIT    = 2'd2;
  localparam logic [1:0] CFG_TIME_CHECK_EN = 2'd3;

  // Register reset values
  localparam logic [3:0]  OWN_NODE_RST      = 4'd0;
  localparam logic [31:0] LEASE_LIMIT_RST   = 32'd7000;
  localparam logic [31:0] SKEW_LIMIT_RST    = 32'd2000;
  localparam logic        TIME_CHECK_EN_RST = 1'b1;

  // Stream widths
  localparam int IN_TDATA_W  = 328;
  localparam int OUT_TDATA_W = 272;

  typedef struct packed {
    logic [3:0]  own_node;
    logic [31:0] lease_limit;
    logic [31:0] skew_limit;
    logic        time_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  sender_node;
    logic [63:0] request_log_pos;
    logic [63:0] local_log_pos;
    logic [63:0] proposal_number;
    logic [3:0]  lease_owner;
    logic [63:0] expire_time;
    logic [63:0] now_time;
  } item_t;

  typedef struct packed {
    reply_kind_t reply_kind;
    logic [3:0]  dest_node;
    logic [3:0]  from_node;
    logic [63:0] reply_proposal;
    logic [63:0] prev_proposal;
    logic [3:0]  prev_owner;
    logic [63:0] prev_expire;
    logic        log_notify;
    logic [63:0] notify_log_pos;
  } result_t;

  typedef struct packed {
    logic [63:0] promised_proposal;
    logic        lease_accepted;
    logic [63:0] accepted_proposal;
    logic [3:0]  accepted_owner;
    logic [63:0] accepted_expire;
  } acc_state_t;

endpackage

/* design/lca_eval.sv */
// ----------------------------------------------------------------------------
// Lease consensus acceptor decision logic
// Combinational evaluation of one request against the acceptor state: expiry
// drop, log position check, promise compare, skew check and state update.
// ----------------------------------------------------------------------------
module lca_eval (
  input  lca_pkg::item_t      item,
  input  lca_pkg::acc_state_t st,
  input  lca_pkg::cfg_t       cfg,
  output logic                has_result,
  output lca_pkg::result_t    res,
  output lca_pkg::acc_state_t st_nxt
);
  import lca_pkg::*;

  logic        lease_live;
  logic        expired;
  logic        log_ok;
  logic        below_promise;
  logic [33:0] skew_window;
  logic [63:0] lease_span;
  logic        skew_fault;

  // Shared compares and the skew window (sum kept exact in 34 bits)
  always_comb begin
    lease_live    = st.lease_accepted && !(st.accepted_expire < item.now_time);
    expired       = item.expire_time < item.now_time;
    log_ok        = !(item.request_log_pos < item.local_log_pos);
    below_promise = item.proposal_number < st.promised_proposal;
    skew_window   = {2'b00, cfg.lease_limit} + {1'b0, cfg.skew_limit, 1'b0};
    lease_span    = item.expire_time - item.now_time;
    skew_fault    = cfg.time_check_enable && (lease_span > {30'd0, skew_window});
  end

  // Reply and next state
  always_comb begin
    st_nxt                = st;
    st_nxt.lease_accepted = lease_live;
    has_result            = 1'b0;
    res                   = '0;
    res.dest_node         = item.sender_node;
    res.from_node         = cfg.own_node;
    res.reply_proposal    = item.proposal_number;
    case (item.req_type)
      REQ_PREPARE: begin
        if (log_ok) begin
          has_result         = 1'b1;
          res.log_notify     = 1'b1;
          res.notify_log_pos = item.request_log_pos;
          if (below_promise) begin
            res.reply_kind = KIND_PREP_REJECT;
          end else begin
            st_nxt.promised_proposal = item.proposal_number;
            if (!lease_live) begin
              res.reply_kind = KIND_PREP_OPEN;
            end else begin
              res.reply_kind    = KIND_PREP_PREV;
              res.prev_proposal = st.accepted_proposal;
              res.prev_owner    = st.accepted_owner;
              res.prev_expire   = st.accepted_expire;
            end
          end
        end
      end
      REQ_PROPOSE: begin
        if (!expired) begin
          has_result = 1'b1;
          if (skew_fault) begin
            res.reply_kind = KIND_SKEW_FAULT;
          end else if (below_promise) begin
            res.reply_kind = KIND_PROP_REJECT;
          end else begin
            res.reply_kind           = KIND_PROP_ACCEPT;
            st_nxt.lease_accepted    = 1'b1;
            st_nxt.accepted_proposal = item.proposal_number;
            st_nxt.accepted_owner    = item.lease_owner;
            st_nxt.accepted_expire   = item.expire_time;
          end
        end
      end
      default: begin
        // tick or unused code: expiry drop only
      end
    endcase
  end

endmodule

/* design/lease_consensus_acceptor_core.sv */
// ----------------------------------------------------------------------------
// Lease consensus acceptor core
// Acceptor side of a lease-granting consensus round, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser = req_type (0 prepare, 1 propose, 2 tick),
//           in_tdata carries the request fields and the current time.
//   out_* : reply stream. out_tuser = reply_kind, out_tdata the reply fields.
//           A request yields zero or one reply; stale prepares, expired
//           proposes and ticks give none.
//   cfg_* : register writes (index, data), always ready. Write only while the
//           block is idle.
//   Path: the input register holds the request, the reply register its reply.
//   Throughput: one request per cycle unless stalled; the update of the
//   promise/lease registers is the loop that sets it.
//   Stall: the reply register holds while out_tready is low; requests that
//   produce no reply still pass, and in_tready drops only once a request that
//   produces a reply is waiting behind the held reply.
//   Reset (rst_n low, synchronous): no lease, promise zero, registers back to
//   own_node 0, lease 7000, skew 2000, time check on; both streams empty.
// ----------------------------------------------------------------------------
module lease_consensus_acceptor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, low to high: sender_node, request_log_pos, local_log_pos,
  // proposal_number, lease_owner, expire_time, now_time
  input  logic [lca_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: req_type
  input  logic [1:0]                         in_tuser,
  // reply stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, low to high: dest_node, from_node, reply_proposal, prev_proposal,
  // prev_owner, prev_expire, log_notify, notify_log_pos, zero pad
  output logic [lca_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: reply_kind
  output logic [2:0]                         out_tuser,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import lca_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  item_t      s1_item_r;
  item_t      in_item;
  acc_state_t st_r;
  acc_state_t st_nxt;
  logic       has_result;
  result_t    res;
  logic       out_valid_r;
  logic       out_valid_nxt;
  result_t    out_res_r;
  logic       advance;

  // Unpack request
  always_comb begin
    in_item.req_type        = in_tuser;
    in_item.sender_node     = in_tdata[3:0];
    in_item.request_log_pos = in_tdata[67:4];
    in_item.local_log_pos   = in_tdata[131:68];
    in_item.proposal_number = in_tdata[195:132];
    in_item.lease_owner     = in_tdata[199:196];
    in_item.expire_time     = in_tdata[263:200];
    in_item.now_time        = in_tdata[327:264];
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node          <= OWN_NODE_RST;
      cfg_r.lease_limit       <= LEASE_LIMIT_RST;
      cfg_r.skew_limit        <= SKEW_LIMIT_RST;
      cfg_r.time_check_enable <= TIME_CHECK_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_NODE:      cfg_r.own_node          <= cfg_data[3:0];
        CFG_LEASE_LIMIT:   cfg_r.lease_limit       <= cfg_data;
        CFG_SKEW_LIMIT:    cfg_r.skew_limit        <= cfg_data;
        CFG_TIME_CHECK_EN: cfg_r.time_check_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Decision logic
  lca_eval u_eval (
    .item       (s1_item_r),
    .st         (st_r),
    .cfg        (cfg_r),
    .has_result (has_result),
    .res        (res),
    .st_nxt     (st_nxt)
  );

  // Handshake: the staged request retires when it has no reply or its reply has room
  assign advance       = s1_valid_r && (!has_result || !out_valid_r || out_tready);
  assign in_tready     = !s1_valid_r || advance;
  assign out_valid_nxt = (advance && has_result) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  // Control and acceptor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
    if (advance && has_result) begin
      out_res_r <= res;
    end
  end

  // Pack reply
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.reply_kind;
  assign out_tdata  = {3'b000,
                       out_res_r.notify_log_pos,
                       out_res_r.log_notify,
                       out_res_r.prev_expire,
                       out_res_r.prev_owner,
                       out_res_r.prev_proposal,
                       out_res_r.reply_proposal,
                       out_res_r.from_node,
                       out_res_r.dest_node};

  // Promise never goes backward
  a_promise_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> st_r.promised_proposal >= $past(st_r.promised_proposal))
    else $error("promised proposal decreased");

  // An accepted propose leaves a live lease behind
  a_accept_sets_lease: assert property (@(posedge clk) disable iff (!rst_n)
    advance && has_result && res.reply_kind == KIND_PROP_ACCEPT |=>
      st_r.lease_accepted && st_r.accepted_proposal == $past(s1_item_r.proposal_number))
    else $error("accepted propose did not store the lease");

  // A skew fault leaves promise and lease contents untouched
  a_skew_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    advance && has_result && res.reply_kind == KIND_SKEW_FAULT |=>
      $stable(st_r.promised_proposal) && $stable(st_r.accepted_proposal) &&
      $stable(st_r.accepted_expire))
    else $error("skew fault changed acceptor state");

  // Log notify only on prepare replies
  a_notify_prepare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.log_notify |->
      (out_res_r.reply_kind == KIND_PREP_REJECT || out_res_r.reply_kind == KIND_PREP_OPEN ||
       out_res_r.reply_kind == KIND_PREP_PREV))
    else $error("log notify on a non-prepare reply");

  // A held reply is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(advance && has_result))
    else $error("reply register overwritten while stalled");

endmodule

/* verif/tb_lease_consensus_acceptor_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lease consensus acceptor core testbench
// Streams prepare, propose and tick requests into the acceptor and checks
// every reply against its table row or a model of promise and lease state.
// A short directed table comes first. Random phases follow, each under its
// own register setting. The request side idles in bursts and the reply side
// stalls to its own pattern, with one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_lease_consensus_acceptor_core;
  import lca_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_COUNT  = 7;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          IDLE_SETTLE  = 4;
  localparam logic [1:0]  REQ_SPARE    = 2'd3;  // unused type, acts like a tick
  localparam logic [63:0] TOP_U64      = '1;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_EVERY3} ready_style_t;

  typedef struct {
    item_t   req;
    bit      typed;
    bit      want;
    result_t rep;
  } dir_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [1:0]             in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [31:0]            cfg_data  = '0;

  // Model state and register shadows
  logic [63:0] promised;
  logic        lease_held;
  logic [63:0] lease_prop;
  logic [3:0]  lease_owner_q;
  logic [63:0] lease_exp;
  logic [3:0]  cfg_own;
  logic [31:0] cfg_lease;
  logic [31:0] cfg_skew;
  logic        cfg_chk;

  result_t      replies_due[$];
  dir_row_t     dir_rows[$];
  int           mismatches = 0;
  int           cycles     = 0;
  logic [63:0]  sim_ms;
  bit           hold_ask   = 1'b0;
  int           hold_left  = 0;
  int           rdy_tick   = 0;
  ready_style_t rdy_style  = RDY_ALWAYS;

  lease_consensus_acceptor_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lease_consensus_acceptor_core: done, errors");
      $finish;
    end
  end

  // Reply side: stall pattern that changes style now and then, plus the long hold
  always @(posedge clk) begin
    rdy_tick++;
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rdy_tick % 97 == 0) rdy_style = ready_style_t'($urandom_range(0, 3));
      case (rdy_style)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RDY_MOSTLY: out_tready <= ($urandom_range(0, 9) != 0);
        default:    out_tready <= (rdy_tick % 3 == 0);
      endcase
    end
  end

  task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      mismatches++;
    end
  endtask

  // Reply checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply_kind: expected no reply, got %0d", out_tuser);
        mismatches++;
      end else begin
        result_t e;
        e = replies_due.pop_front();
        cmp("reply_kind",     e.reply_kind,     out_tuser);
        cmp("dest_node",      e.dest_node,      out_tdata[3:0]);
        cmp("from_node",      e.from_node,      out_tdata[7:4]);
        cmp("reply_proposal", e.reply_proposal, out_tdata[71:8]);
        cmp("prev_proposal",  e.prev_proposal,  out_tdata[135:72]);
        cmp("prev_owner",     e.prev_owner,     out_tdata[139:136]);
        cmp("prev_expire",    e.prev_expire,    out_tdata[203:140]);
        cmp("log_notify",     e.log_notify,     out_tdata[204]);
        cmp("notify_log_pos", e.notify_log_pos, out_tdata[268:205]);
      end
    end
  end

  // Acceptor decision: expiry drop first, then prepare or propose handling
  function automatic bit predict_reply(input item_t r, output result_t rep);
    logic [64:0] win;
    logic [63:0] span;
    rep = '0;
    if (lease_held && lease_exp < r.now_time) lease_held = 1'b0;
    rep.dest_node      = r.sender_node;
    rep.from_node      = cfg_own;
    rep.reply_proposal = r.proposal_number;
    case (r.req_type)
      REQ_PREPARE: begin
        if (r.request_log_pos < r.local_log_pos) return 1'b0;
        rep.log_notify     = 1'b1;
        rep.notify_log_pos = r.request_log_pos;
        if (r.proposal_number < promised) begin
          rep.reply_kind = KIND_PREP_REJECT;
        end else begin
          promised = r.proposal_number;
          if (!lease_held) begin
            rep.reply_kind = KIND_PREP_OPEN;
          end else begin
            rep.reply_kind    = KIND_PREP_PREV;
            rep.prev_proposal = lease_prop;
            rep.prev_owner    = lease_owner_q;
            rep.prev_expire   = lease_exp;
          end
        end
        return 1'b1;
      end
      REQ_PROPOSE: begin
        if (r.expire_time < r.now_time) return 1'b0;
        win  = {33'd0, cfg_lease} + {32'd0, cfg_skew, 1'b0};
        span = r.expire_time - r.now_time;
        if (cfg_chk && {1'b0, span} > win) begin
          rep.reply_kind = KIND_SKEW_FAULT;
        end else if (r.proposal_number < promised) begin
          rep.reply_kind = KIND_PROP_REJECT;
        end else begin
          lease_held     = 1'b1;
          lease_prop     = r.proposal_number;
          lease_owner_q  = r.lease_owner;
          lease_exp      = r.expire_time;
          rep.reply_kind = KIND_PROP_ACCEPT;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mk_req(input logic [1:0] kind, input logic [3:0] sender,
                                   input logic [63:0] rpos, input logic [63:0] lpos,
                                   input logic [63:0] prop, input logic [3:0] owner,
                                   input logic [63:0] expv, input logic [63:0] now);
    item_t r;
    r.req_type        = kind;
    r.sender_node     = sender;
    r.request_log_pos = rpos;
    r.local_log_pos   = lpos;
    r.proposal_number = prop;
    r.lease_owner     = owner;
    r.expire_time     = expv;
    r.now_time        = now;
    return r;
  endfunction

  // Reply as seen under the reset value of own_node
  function automatic result_t mk_rep(input reply_kind_t kind, input logic [3:0] dest,
                                     input logic [63:0] prop, input logic [63:0] npos,
                                     input logic [63:0] pprop, input logic [3:0] powner,
                                     input logic [63:0] pexp);
    result_t p;
    p = '0;
    p.reply_kind     = kind;
    p.dest_node      = dest;
    p.from_node      = OWN_NODE_RST;
    p.reply_proposal = prop;
    p.prev_proposal  = pprop;
    p.prev_owner     = powner;
    p.prev_expire    = pexp;
    p.log_notify     = (kind == KIND_PREP_REJECT || kind == KIND_PREP_OPEN ||
                        kind == KIND_PREP_PREV);
    p.notify_log_pos = p.log_notify ? npos : 64'd0;
    return p;
  endfunction

  task automatic add_row(input item_t r, input bit typed, input bit want, input result_t p);
    dir_row_t d;
    d.req   = r;
    d.typed = typed;
    d.want  = want;
    d.rep   = p;
    dir_rows.push_back(d);
  endtask

  // Random request, mostly shaped around the current promise and lease window
  function automatic item_t gen_req();
    item_t       r;
    logic [64:0] win;
    int          pick;
    int          lim;
    r.req_type        = 2'($urandom_range(0, 3));
    r.sender_node     = 4'($urandom);
    r.request_log_pos = rand64();
    r.local_log_pos   = rand64();
    r.proposal_number = rand64();
    r.lease_owner     = 4'($urandom);
    r.expire_time     = rand64();
    r.now_time        = rand64();
    if ($urandom_range(0, 99) < 8) return r;

    win = {33'd0, cfg_lease} + {32'd0, cfg_skew, 1'b0};
    lim = (win > 65'd20000) ? 20000 : int'(win);
    sim_ms     += $urandom_range(0, 2500);
    r.now_time  = sim_ms;
    pick = $urandom_range(0, 99);
    r.req_type = (pick < 42) ? REQ_PREPARE : (pick < 84) ? REQ_PROPOSE :
                 (pick < 94) ? REQ_TICK : REQ_SPARE;

    pick = $urandom_range(0, 9);
    if (pick < 2)       r.proposal_number = promised - $urandom_range(1, 3);
    else if (pick > 2)  r.proposal_number = promised + $urandom_range(0, 3);

    if ($urandom_range(0, 6) == 0)
      r.request_log_pos = r.local_log_pos - $urandom_range(1, 50);
    else
      r.request_log_pos = r.local_log_pos + $urandom_range(0, 2);

    pick = $urandom_range(0, 19);
    if (pick < 2)       r.expire_time = r.now_time - $urandom_range(1, 100);
    else if (pick < 4)  r.expire_time = r.now_time + win[63:0] + 64'($urandom_range(1, 5));
    else if (pick == 4) r.expire_time = r.now_time + win[63:0];
    else                r.expire_time = r.now_time + $urandom_range(0, lim);
    return r;
  endfunction

  task automatic offer(input item_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.req_type;
    in_tdata  <= {r.now_time, r.expire_time, r.lease_owner, r.proposal_number,
                  r.local_log_pos, r.request_log_pos, r.sender_node};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Model update at acceptance; typed rows queue their written-out reply
  task automatic log_request(input item_t r, input bit typed, input bit want,
                             input result_t p);
    result_t m;
    bit      has;
    has = predict_reply(r, m);
    if (typed) begin
      if (want) replies_due.push_back(p);
    end else if (has) begin
      replies_due.push_back(m);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_OWN_NODE:    cfg_own   = val[3:0];
      CFG_LEASE_LIMIT: cfg_lease = val;
      CFG_SKEW_LIMIT:  cfg_skew  = val;
      default:         cfg_chk   = val[0];
    endcase
  endtask

  task automatic load_settings(input logic [3:0] own, input logic [31:0] lease,
                               input logic [31:0] skew, input logic chk);
    write_reg(CFG_OWN_NODE, {28'($urandom), own});
    write_reg(CFG_LEASE_LIMIT, lease);
    write_reg(CFG_SKEW_LIMIT, skew);
    write_reg(CFG_TIME_CHECK_EN, {31'($urandom), chk});
    cfg_valid <= 1'b0;
  endtask

  // Wait for every outstanding reply, then let requests without one drain
  task automatic settle();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  initial begin : main
    item_t   r;
    result_t none;
    int      gap;
    int      burst_left;
    none          = '0;
    burst_left    = 0;
    promised      = '0;
    lease_held    = 1'b0;
    lease_prop    = '0;
    lease_owner_q = '0;
    lease_exp     = '0;
    cfg_own       = OWN_NODE_RST;
    cfg_lease     = LEASE_LIMIT_RST;
    cfg_skew      = SKEW_LIMIT_RST;
    cfg_chk       = TIME_CHECK_EN_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under reset settings: lease window is 11000 ms
    add_row(mk_req(REQ_TICK, 4'd0, 0, 0, 0, 4'd0, 0, 0), 1, 0, none);
    add_row(mk_req(REQ_PREPARE, 4'd15, 0, 0, 0, 4'd0, 0, 0), 1, 1,
            mk_rep(KIND_PREP_OPEN, 4'd15, 0, 0, 0, 4'd0, 0));
    // stale log position
    add_row(mk_req(REQ_PREPARE, 4'd1, 5, 6, 9, 4'd0, 0, 0), 1, 0, none);
    add_row(mk_req(REQ_PREPARE, 4'd0, TOP_U64, TOP_U64, TOP_U64, 4'd0, 0, 0), 1, 1,
            mk_rep(KIND_PREP_OPEN, 4'd0, TOP_U64, TOP_U64, 0, 4'd0, 0));
    add_row(mk_req(REQ_PREPARE, 4'd3, 7, 0, 100, 4'd0, 0, 0), 1, 1,
            mk_rep(KIND_PREP_REJECT, 4'd3, 100, 7, 0, 4'd0, 0));
    // expiry exactly at the edge of the window is still fine
    add_row(mk_req(REQ_PROPOSE, 4'd4, 0, 0, TOP_U64, 4'd15, 11000, 0), 1, 1,
            mk_rep(KIND_PROP_ACCEPT, 4'd4, TOP_U64, 0, 0, 4'd0, 0));
    add_row(mk_req(REQ_PROPOSE, 4'd5, 0, 0, TOP_U64, 4'd1, 11001, 0), 1, 1,
            mk_rep(KIND_SKEW_FAULT, 4'd5, TOP_U64, 0, 0, 4'd0, 0));
    add_row(mk_req(REQ_PROPOSE, 4'd6, 0, 0, 5, 4'd2, 100, 0), 1, 1,
            mk_rep(KIND_PROP_REJECT, 4'd6, 5, 0, 0, 4'd0, 0));
    // already expired
    add_row(mk_req(REQ_PROPOSE, 4'd7, 0, 0, TOP_U64, 4'd3, 4, 5), 1, 0, none);
    // lease survives while expiry equals now
    add_row(mk_req(REQ_PREPARE, 4'd8, 1, 1, TOP_U64, 4'd0, 0, 11000), 1, 1,
            mk_rep(KIND_PREP_PREV, 4'd8, TOP_U64, 1, TOP_U64, 4'd15, 11000));
    add_row(mk_req(REQ_TICK, 4'd0, 0, 0, 0, 4'd0, 0, 11001), 1, 0, none);
    add_row(mk_req(REQ_PREPARE, 4'd9, 2, 1, TOP_U64, 4'd0, 0, 11001), 1, 1,
            mk_rep(KIND_PREP_OPEN, 4'd9, TOP_U64, 2, 0, 4'd0, 0));
    add_row(mk_req(REQ_PROPOSE, 4'd10, 0, 0, TOP_U64, 4'd6, TOP_U64, TOP_U64), 1, 1,
            mk_rep(KIND_PROP_ACCEPT, 4'd10, TOP_U64, 0, 0, 4'd0, 0));
    add_row(mk_req(REQ_SPARE, 4'd15, TOP_U64, TOP_U64, TOP_U64, 4'd15, TOP_U64, TOP_U64),
            1, 0, none);
    add_row(mk_req(REQ_PREPARE, 4'd11, 0, 0, TOP_U64, 4'd0, 0, TOP_U64), 1, 1,
            mk_rep(KIND_PREP_PREV, 4'd11, TOP_U64, 0, TOP_U64, 4'd6, TOP_U64));
    add_row(mk_req(REQ_PROPOSE, 4'd12, 0, 0, TOP_U64 - 1, 4'd9, TOP_U64, TOP_U64 - 1),
            1, 1, mk_rep(KIND_PROP_REJECT, 4'd12, TOP_U64 - 1, 0, 0, 4'd0, 0));
    // time going backwards, left to the model
    add_row(mk_req(REQ_PREPARE, 4'd13, 0, TOP_U64, 3, 4'd0, 0, 0), 0, 0, none);
    add_row(mk_req(REQ_PREPARE, 4'd14, 0, 0, 0, 4'd0, 0, 0), 0, 0, none);
    add_row(mk_req(REQ_PROPOSE, 4'd2, 0, 0, TOP_U64, 4'd5, 20000, 0), 0, 0, none);
    add_row(mk_req(REQ_PROPOSE, 4'd1, 0, 0, TOP_U64, 4'd10, 10999, 1), 0, 0, none);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].req);
      log_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, dir_rows[i].rep);
    end
    in_tvalid <= 1'b0;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        0: load_settings(4'd15, 32'd0, 32'd0, 1'b1);
        1: load_settings(4'd0, '1, '1, 1'b1);
        2: load_settings(4'($urandom), 32'd7000, 32'd2000, 1'b0);
        3: load_settings(4'($urandom), $urandom_range(0, 5000), $urandom_range(0, 2000),
                         1'b1);
        4: load_settings(4'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)));
        5: load_settings(4'($urandom), 32'd1, 32'd0, 1'b1);
        default: load_settings(4'($urandom), $urandom_range(0, 20000),
                               $urandom_range(0, 4000), 1'($urandom_range(0, 1)));
      endcase
      sim_ms = rand64() >> $urandom_range(1, 63);
      // long reply hold-off while requests keep coming back to back
      if (ph == 3) hold_ask = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left <= 0 && ph != 3) begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        r = gen_req();
        offer(r);
        log_request(r, 1'b0, 1'b0, none);
        burst_left--;
      end
      in_tvalid <= 1'b0;
    end

    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb_lease_consensus_acceptor_core: done, clean");
    end else begin
      $display("tb_lease_consensus_acceptor_core: done, errors");
    end
    $finish;
  end

endmodule
